// ----- hdl/bsa_pkg.sv -----
// Bitmap slot allocator: shared constants, item kinds, FSM states and
// the command/status structs between controller and datapath.
// No dependencies.
package bsa_pkg;

  // Map geometry
  localparam int MAX_SLOTS  = 256;
  localparam int SLOT_LIMIT = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
  localparam int WORDS      = (SLOT_LIMIT + 31) / 32;
  localparam int WORD_W     = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Field widths
  localparam int KIND_W = 2;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;

  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

  // Item kinds; code 3 is a no-op
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_QUERY   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // latch a new item, restart scan
    logic step;   // examine one map word
    logic emit;   // finish item, load output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic found;
    logic last_word;
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/bsa_if.sv -----
// Bitmap slot allocator: valid/ready channel interfaces for items in and
// results out. Depends on bsa_pkg.
interface bsa_in_if;
  logic                     valid;
  logic                     ready;
  logic [bsa_pkg::KIND_W-1:0] kind;
  logic [bsa_pkg::IDX_W-1:0]  slot_index;

  modport source (output valid, kind, slot_index, input ready);
  modport sink   (input valid, kind, slot_index, output ready);
endinterface

interface bsa_out_if;
  logic                      valid;
  logic                      ready;
  logic                      granted;
  logic [bsa_pkg::IDX_W-1:0] granted_index;
  logic                      slot_busy;

  modport source (output valid, granted, granted_index, slot_busy, input ready);
  modport sink   (input valid, granted, granted_index, slot_busy, output ready);
endinterface

// ----- hdl/bitmap_slot_allocator.sv -----
// Bitmap slot allocator top level: joins controller and datapath to the
// channel interfaces. Depends on bsa_pkg, bsa_if, bsa_ctrl, bsa_datapath.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      kind, slot_index
//   out_ch    out  valid/ready      granted, granted_index, slot_busy
//   cfg       in   cfg_we           cfg_wdata (slot count)
//
// One item at a time. Release and query pass through accept, decode and
// finish; the result is loaded into the output register on finish.
// Allocate passes through accept, a one-word-per-cycle scan of k map words
// (1..8) and finish; its result is loaded into the output register on finish.
// A result waits in the output register while the next item is accepted;
// a stalled output holds the item in its final state.
// Reset and any count write clear the whole map.
module bitmap_slot_allocator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bsa_pkg::CNT_W-1:0] cfg_wdata,
  bsa_in_if.sink                    in_ch,
  bsa_out_if.source                 out_ch
);

  bsa_pkg::cmd_t cmd;
  bsa_pkg::sts_t sts;

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bsa_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_kind           (in_ch.kind),
    .in_slot_index     (in_ch.slot_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_granted       (out_ch.granted),
    .out_granted_index (out_ch.granted_index),
    .out_slot_busy     (out_ch.slot_busy)
  );

`ifndef SYNTH
  // An accepted item blocks the input for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after accept");

  // No grant means a zero index
  a_no_grant_index: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.granted) |-> (out_ch.granted_index == '0))
    else $error("index given without grant");

  // A result never carries both a grant and a query mark
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.granted && out_ch.slot_busy))
    else $error("grant and busy both set");
`endif

endmodule

// ----- hdl/bsa_ctrl.sv -----
// Bitmap slot allocator: control state machine (accept, scan, finish).
// Depends on bsa_pkg.
module bsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output bsa_pkg::cmd_t cmd,
  input  bsa_pkg::sts_t sts
);

  bsa_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      bsa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bsa_pkg::ST_SCAN;
        end
      end
      bsa_pkg::ST_SCAN: begin
        // release/query/no-op skip straight through; allocate walks the words
        if (!sts.is_alloc) begin
          state_next = bsa_pkg::ST_DONE;
        end else begin
          cmd.step = 1'b1;
          if (sts.found || sts.last_word) begin
            state_next = bsa_pkg::ST_DONE;
          end
        end
      end
      bsa_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = bsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/bsa_datapath.sv -----
// Bitmap slot allocator: usage map, slot-count register, word scanner and
// output register. Depends on bsa_pkg.
module bsa_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bsa_pkg::CNT_W-1:0] cfg_wdata,
  input  logic [bsa_pkg::KIND_W-1:0] in_kind,
  input  logic [bsa_pkg::IDX_W-1:0] in_slot_index,
  input  bsa_pkg::cmd_t             cmd,
  output bsa_pkg::sts_t             sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_granted,
  output logic [bsa_pkg::IDX_W-1:0] out_granted_index,
  output logic                      out_slot_busy
);

  logic [31:0]                  usage_map [bsa_pkg::WORDS];
  logic [bsa_pkg::CNT_W-1:0]    slots_in_use;
  logic [bsa_pkg::CNT_W-1:0]    count;
  logic [bsa_pkg::KIND_W-1:0]   kind_q;
  logic [bsa_pkg::IDX_W-1:0]    idx_q;
  logic [bsa_pkg::WORD_W-1:0]   word_ctr;
  logic                         res_granted;
  logic [bsa_pkg::IDX_W-1:0]    res_index;
  logic [31:0]                  word_mask;
  logic [31:0]                  free_bits;
  logic                         hit;
  logic [4:0]                   hit_bit;
  logic [bsa_pkg::WORD_W-1:0]   idx_word;
  logic                         in_range;
  logic                         mark;

  // Effective slot count
  assign count = (slots_in_use > bsa_pkg::CNT_W'(bsa_pkg::SLOT_LIMIT)) ?
                 bsa_pkg::CNT_W'(bsa_pkg::SLOT_LIMIT) : slots_in_use;

  // Valid-slot mask for the word under scan
  always_comb begin
    for (int b = 0; b < 32; b++) begin
      word_mask[b] = bsa_pkg::CNT_W'({word_ctr, 5'(b)}) < count;
    end
  end

  assign free_bits = ~usage_map[word_ctr] & word_mask;

  // Lowest free bit in the word
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = 31; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit     = 1'b1;
        hit_bit = 5'(b);
      end
    end
  end

  // Single-slot lookup for release and query
  assign idx_word = bsa_pkg::WORD_W'(idx_q >> 5);
  assign in_range = {1'b0, idx_q} < count;
  assign mark     = usage_map[idx_word][idx_q[4:0]];

  assign sts.is_alloc  = (kind_q == bsa_pkg::KIND_ALLOC);
  assign sts.found     = hit;
  assign sts.last_word = (word_ctr == bsa_pkg::WORD_W'(bsa_pkg::WORDS - 1));
  assign sts.out_busy  = out_valid && !out_ready;

  // Slot-count register
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= bsa_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      slots_in_use <= cfg_wdata;
    end
  end

  // Usage map: cleared at reset and on count write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int w = 0; w < bsa_pkg::WORDS; w++) begin
        usage_map[w] <= '0;
      end
    end else if (cmd.step && hit) begin
      usage_map[word_ctr][hit_bit] <= 1'b1;
    end else if (cmd.emit && kind_q == bsa_pkg::KIND_RELEASE && in_range) begin
      usage_map[idx_word][idx_q[4:0]] <= 1'b0;
    end
  end

  // Item latch and scan state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q      <= in_kind;
      idx_q       <= in_slot_index;
      word_ctr    <= '0;
      res_granted <= 1'b0;
      res_index   <= '0;
    end else if (cmd.step) begin
      if (hit) begin
        res_granted <= 1'b1;
        res_index   <= bsa_pkg::IDX_W'({word_ctr, hit_bit});
      end else if (!sts.last_word) begin
        word_ctr <= word_ctr + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_granted       <= sts.is_alloc && res_granted;
      out_granted_index <= sts.is_alloc ? res_index : '0;
      out_slot_busy     <= (kind_q == bsa_pkg::KIND_QUERY) && in_range && mark;
    end
  end

endmodule

// ----- test/bitmap_slot_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_slot_allocator: random valid/ready traffic with a
// behavioral slot-map model that predicts every result. Depends on bsa_pkg, bsa_if, RTL.
module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SEGMENTS     = 12;
  localparam int SEG_ITEMS    = 165;

  // Kind code 3 has no enum member in the package; the block treats it as a no-op
  localparam logic [KIND_W-1:0] KIND_NOOP = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  slot_index;
  } slot_req_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] granted_index;
    logic             slot_busy;
  } slot_resp_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  bsa_in_if  in_ch ();
  bsa_out_if out_ch ();

  bitmap_slot_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Model state: one mark per slot plus the programmed count
  logic [SLOT_LIMIT-1:0] slot_marks;
  logic [CNT_W-1:0]      slot_count;

  slot_req_t  pending_items[$];
  slot_resp_t expected_results[$];

  int in_idle_pct;
  int out_idle_pct;
  int fail_count;
  int cycle_count;

  // Count actually usable: capped by the map size
  function automatic int usable_slots(input logic [CNT_W-1:0] cnt);
    return (int'(cnt) > SLOT_LIMIT) ? SLOT_LIMIT : int'(cnt);
  endfunction

  // Apply one item to the model map and return the result it should produce
  function automatic slot_resp_t apply_slot_req(input slot_req_t req);
    slot_resp_t r;
    int         n;
    r = '0;
    n = usable_slots(slot_count);
    case (req.kind)
      KIND_ALLOC: begin
        for (int i = 0; i < n; i++) begin
          if (!slot_marks[i]) begin
            slot_marks[i]   = 1'b1;
            r.granted       = 1'b1;
            r.granted_index = i[IDX_W-1:0];
            break;
          end
        end
      end
      KIND_RELEASE: begin
        if (int'(req.slot_index) < n) slot_marks[req.slot_index] = 1'b0;
      end
      KIND_QUERY: begin
        if (int'(req.slot_index) < n) r.slot_busy = slot_marks[req.slot_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Clock and cycle guard
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Item driver: predicts on accept, then presents the next pending item
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_slot_req('{in_ch.kind, in_ch.slot_index}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          slot_req_t nxt;
          nxt = pending_items.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.kind       <= nxt.kind;
          in_ch.slot_index <= nxt.slot_index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, randomize ready
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: granted=%0d index=%0d busy=%0d",
                 out_ch.granted, out_ch.granted_index, out_ch.slot_busy);
          fail_count++;
        end else begin
          slot_resp_t exp_r;
          exp_r = expected_results.pop_front();
          if (out_ch.granted !== exp_r.granted) begin
            $error("granted: expected %0d, got %0d", exp_r.granted, out_ch.granted);
            fail_count++;
          end
          if (out_ch.granted_index !== exp_r.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   exp_r.granted_index, out_ch.granted_index);
            fail_count++;
          end
          if (out_ch.slot_busy !== exp_r.slot_busy) begin
            $error("slot_busy: expected %0d, got %0d", exp_r.slot_busy, out_ch.slot_busy);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic push_item(input logic [KIND_W-1:0] kind, input int idx);
    pending_items.push_back('{kind, idx[IDX_W-1:0]});
  endtask

  // Nothing queued, nothing on the wire, nothing outstanding; sampled at the
  // falling edge so the driver's updates from the last rising edge are settled
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Count writes happen only with the block idle; they also clear the map
  task automatic write_count(input logic [CNT_W-1:0] value);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    slot_count = value;
    slot_marks = '0;
    @(posedge clk);
  endtask

  // Random traffic in bursts: fill runs, release runs, query runs, a little noise
  task automatic queue_random_segment(input int n_items, input int n_usable);
    int burst_left;
    int mode;
    int roll;
    int idx;
    logic [KIND_W-1:0] kind;
    burst_left = 0;
    mode       = 0;
    repeat (n_items) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        mode       = $urandom_range(0, 2);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        kind = KIND_NOOP;
      end else begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       kind = (roll < 80) ? KIND_ALLOC : (roll < 92) ? KIND_RELEASE : KIND_QUERY;
          1:       kind = (roll < 30) ? KIND_ALLOC : (roll < 80) ? KIND_RELEASE : KIND_QUERY;
          default: kind = (roll < 30) ? KIND_ALLOC : (roll < 45) ? KIND_RELEASE : KIND_QUERY;
        endcase
      end
      // Mostly in range; some anywhere to hit the out-of-range paths
      if (n_usable == 0 || $urandom_range(0, 9) == 0) idx = $urandom_range(0, 255);
      else idx = $urandom_range(0, n_usable - 1);
      push_item(kind, idx);
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [CNT_W-1:0] count_plan [SEGMENTS];

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = '0;
    in_ch.slot_index = '0;
    out_ch.ready     = 1'b0;
    fail_count       = 0;
    cycle_count      = 0;
    slot_marks       = '0;
    slot_count       = COUNT_RESET;
    in_idle_pct      = 9;
    out_idle_pct     = 73;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset count, lowest-first allocation, release, query extremes, no-op
    push_item(KIND_QUERY, 0);
    push_item(KIND_ALLOC, 255);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_QUERY, 1);
    push_item(KIND_QUERY, 255);
    push_item(KIND_RELEASE, 0);
    push_item(KIND_QUERY, 0);
    push_item(KIND_ALLOC, 170);
    push_item(KIND_NOOP, 255);
    push_item(KIND_RELEASE, 255);
    push_item(KIND_QUERY, 200);

    // Single slot: map full, out-of-range release and query
    write_count(9'd1);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_QUERY, 0);
    push_item(KIND_QUERY, 1);
    push_item(KIND_RELEASE, 1);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_RELEASE, 0);
    push_item(KIND_ALLOC, 0);

    // Zero count: nothing valid
    write_count(9'd0);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_RELEASE, 0);
    push_item(KIND_QUERY, 0);

    // Count above the map size is capped
    write_count(9'd511);
    push_item(KIND_ALLOC, 0);
    push_item(KIND_QUERY, 255);
    push_item(KIND_RELEASE, 255);

    count_plan = '{9'd256, 9'd1, 9'd17, 9'd511, 9'd33, 9'd0,
                   9'd64, 9'd300, 9'd8, 9'd255, 9'd0, 9'd0};
    count_plan[10] = CNT_W'($urandom_range(2, 31));
    count_plan[11] = CNT_W'($urandom_range(0, 511));

    // Random: receiver-bound, then sender-bound, then full rate
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_count(count_plan[seg]);
      case (seg / 4)
        0:       begin in_idle_pct = 9;  out_idle_pct = 73; end
        1:       begin in_idle_pct = 73; out_idle_pct = 9;  end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      queue_random_segment(SEG_ITEMS, usable_slots(count_plan[seg]));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
